@@ src/swks_pkg.sv @@
// Shared types and constants for the sliding-window KS drift detector.
// Depends on nothing; used by the detector top level.
package swks_pkg;

    // Default sizes of the key domain and of the sliding window.
    localparam int DOMAIN_MAX_DEF = 256;
    localparam int WINDOW_MAX_DEF = 4096;

    // Field and register widths fixed by the interface.
    localparam int OPCODE_W   = 2;
    localparam int KEY_W      = 8;
    localparam int STAT_W     = 17;
    localparam int FILL_W     = 13;
    localparam int DOM_CFG_W  = 9;
    localparam int WIN_CFG_W  = 13;
    localparam int SIG_CFG_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNIFICANCE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DOM_CFG_W-1:0] DOMAIN_RESET = 9'd256;
    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 13'd4096;
    localparam logic [SIG_CFG_W-1:0] SIG_RESET    = 3'd2;

    // Operation codes carried in each input beat.
    typedef enum logic [OPCODE_W-1:0] {
        OP_OBSERVE  = 2'd0,
        OP_QUERY    = 2'd1,
        OP_SNAPSHOT = 2'd2,
        OP_NOP      = 2'd3
    } opcode_t;

    // Fraction bits of the statistic and width of the divider step count.
    localparam int KS_FRAC = 16;
    localparam int DCNT_W  = 5;

    // Scale of the critical-value test: D^2 * n * 10000 >= 2 * c100^2.
    localparam int CONF_SCALE   = 10000;
    localparam int TWO_C2_W     = 16;
    localparam int ALPHA_TOP    = 4;

    // Returns 2 * c100^2 for an alpha band; bands above the last use the last.
    function automatic logic [TWO_C2_W-1:0] two_c_sq(input logic [SIG_CFG_W-1:0] band);
        logic [TWO_C2_W-1:0] v;
        begin
            case (band)
                3'd0:    v = 16'd53138;  // c100 = 163
                3'd1:    v = 16'd46208;  // c100 = 152
                3'd2:    v = 16'd36992;  // c100 = 136
                3'd3:    v = 16'd29768;  // c100 = 122
                default: v = 16'd22898;  // c100 = 107
            endcase
            return v;
        end
    endfunction

endpackage

@@ src/swks_mul.sv @@
// Shift-and-add multiplier that handles one multiplier bit per cycle.
// Depends on nothing outside this file; instantiated by the detector top level.
module swks_mul #(
    parameter int MW = 81,
    parameter int BW = 26
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          busy,
    output logic [MW-1:0] product
);

    logic          busy_reg, busy_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;

    // Each cycle adds the shifted multiplicand when the low multiplier bit is set.
    always_comb begin
        busy_next = busy_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[MW-2:0], 1'b0};
                b_next = {1'b0, b_reg[BW-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

@@ src/sliding_window_ks_drift_detector.sv @@
// Sliding-window drift detector using a two-sample Kolmogorov-Smirnov test.
// Depends on swks_pkg and swks_mul.
//
// Every input beat gives exactly one result beat. After reset the block
// clears both histograms, one entry per cycle, before it accepts its first
// beat; configuration writes are taken throughout. An observe writes the key
// into the ring and increments its count; when the window is full it first
// reads and decrements the count of the oldest key. A key outside the domain
// or the unused opcode goes straight to the result. A snapshot copies the
// whole histogram. A query walks the effective domain key by key, then runs a
// 17-step divider and five shift-add multiplications of one multiplier bit
// per cycle; a query on an empty histogram goes straight to the result. The
// block accepts one item at a time; a finished result may wait in the output
// register while the next item is accepted.
module sliding_window_ks_drift_detector #(
    parameter int DOMAIN_MAX = swks_pkg::DOMAIN_MAX_DEF,
    parameter int WINDOW_MAX = swks_pkg::WINDOW_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [swks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swks_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input beats: tdata = key[7:0]; tuser = opcode[1:0].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swks_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [swks_pkg::OPCODE_W-1:0]      s_tuser,
    // Result beats: tdata = ks_stat_q16[16:0], drift_changed[17],
    // key_error[18], window_fill[31:19].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swks_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int AW = (DOMAIN_MAX > 1) ? $clog2(DOMAIN_MAX) : 1;
    localparam int DW = $clog2(DOMAIN_MAX + 1);
    localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int PW = 2 * CW;
    localparam int BW = (PW > swks_pkg::TWO_C2_W) ? PW : swks_pkg::TWO_C2_W;
    localparam int MW = 5 * CW + 16;
    localparam int KW = swks_pkg::KEY_W;

    // Steps of the threshold multiplication sequence.
    localparam logic [2:0] MS_BEST_SQ  = 3'd0;
    localparam logic [2:0] MS_TIMES_N  = 3'd1;
    localparam logic [2:0] MS_TIMES_K  = 3'd2;
    localparam logic [2:0] MS_DEN_SQ   = 3'd3;
    localparam logic [2:0] MS_TIMES_C  = 3'd4;

    typedef enum logic [15:0] {
        S_CLEAR    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_OBS_EV1  = 16'h0004,
        S_OBS_EV2  = 16'h0008,
        S_OBS_INC1 = 16'h0010,
        S_OBS_INC2 = 16'h0020,
        S_SNAP_RD  = 16'h0040,
        S_SNAP_WR  = 16'h0080,
        S_WALK_RD  = 16'h0100,
        S_WALK_ACC = 16'h0200,
        S_WALK_MUL = 16'h0400,
        S_WALK_CMP = 16'h0800,
        S_DIV      = 16'h1000,
        S_MISSUE   = 16'h2000,
        S_MWAIT    = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    // Memories: key ring and the two histograms.
    logic [KW-1:0] ring_mem [WINDOW_MAX];
    logic [CW-1:0] run_mem  [DOMAIN_MAX];
    logic [CW-1:0] ref_mem  [DOMAIN_MAX];
    logic [KW-1:0] ring_q;
    logic [CW-1:0] run_q, ref_q;

    // Control and datapath registers.
    state_t                           state_reg, state_next;
    logic [swks_pkg::DOM_CFG_W-1:0]   dom_cfg_reg;
    logic [swks_pkg::WIN_CFG_W-1:0]   win_cfg_reg;
    logic [swks_pkg::SIG_CFG_W-1:0]   sig_cfg_reg;
    logic [RW-1:0]                    head_reg, head_next;
    logic [CW-1:0]                    fill_reg, fill_next;
    logic [CW-1:0]                    rtot_reg, rtot_next;
    logic [DW-1:0]                    idx_reg, idx_next;
    logic [KW-1:0]                    key_reg, key_next;
    logic [CW-1:0]                    rc_reg, rc_next;
    logic [CW-1:0]                    sc_reg, sc_next;
    logic [PW-1:0]                    x_reg, x_next;
    logic [PW-1:0]                    y_reg, y_next;
    logic [PW-1:0]                    best_reg, best_next;
    logic [PW-1:0]                    den_reg, den_next;
    logic [PW:0]                      rem_reg, rem_next;
    logic [swks_pkg::STAT_W-1:0]      quo_reg, quo_next;
    logic [swks_pkg::DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [2:0]                       mstep_reg, mstep_next;
    logic [MW-1:0]                    lhs_reg, lhs_next;
    logic                             chg_reg, chg_next;
    logic                             err_reg, err_next;
    logic                             m_valid_reg, m_valid_next;
    logic [swks_pkg::OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    // Memory port controls.
    logic          run_we, ref_we;
    logic [AW-1:0] run_waddr, run_raddr, ref_waddr;
    logic [CW-1:0] run_wdata, ref_wdata;
    logic          ring_we;
    logic [RW-1:0] ring_waddr;

    // Shared multiplier.
    logic          mul_start, mul_busy;
    logic [MW-1:0] mul_a, mul_prod;
    logic [BW-1:0] mul_b;

    // Derived values.
    logic [DW-1:0] eff_dom;
    logic [CW-1:0] eff_win;
    logic          in_accept;
    logic [swks_pkg::OPCODE_W-1:0] in_op;
    logic [KW-1:0] in_key;
    logic [CW:0]   pos_sum;
    logic [PW-1:0] diff;
    logic [PW-1:0] best_upd;
    logic [PW:0]   rem_sh;
    logic          out_free;

    assign in_op     = s_tuser;
    assign in_key    = s_tdata[KW-1:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Effective domain and window sizes, with zero read as one and saturation.
    always_comb begin
        if (dom_cfg_reg == '0) begin
            eff_dom = DW'(1);
        end else if (32'(dom_cfg_reg) > DOMAIN_MAX) begin
            eff_dom = DW'(DOMAIN_MAX);
        end else begin
            eff_dom = DW'(dom_cfg_reg);
        end
        if (win_cfg_reg == '0) begin
            eff_win = CW'(1);
        end else if (32'(win_cfg_reg) > WINDOW_MAX) begin
            eff_win = CW'(WINDOW_MAX);
        end else begin
            eff_win = CW'(win_cfg_reg);
        end
    end

    // Ring slot after the current tail, wrapped once.
    always_comb begin
        pos_sum = (CW + 1)'(head_reg) + (CW + 1)'(fill_reg);
        if (32'(pos_sum) >= WINDOW_MAX) begin
            pos_sum = pos_sum - (CW + 1)'(WINDOW_MAX);
        end
    end

    // Absolute CDF difference and running maximum.
    assign diff     = (x_reg > y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);
    assign best_upd = (diff > best_reg) ? diff : best_reg;
    assign rem_sh   = (dcnt_reg == '0) ? rem_reg : {rem_reg[PW-1:0], 1'b0};

    // Memory port selection by state.
    always_comb begin
        run_we     = 1'b0;
        run_waddr  = idx_reg[AW-1:0];
        run_wdata  = '0;
        run_raddr  = idx_reg[AW-1:0];
        ref_we     = 1'b0;
        ref_waddr  = idx_reg[AW-1:0];
        ref_wdata  = '0;
        ring_we    = 1'b0;
        ring_waddr = RW'(pos_sum);
        case (state_reg)
            S_CLEAR: begin
                run_we = 1'b1;
                ref_we = 1'b1;
            end
            S_OBS_EV1: begin
                run_raddr = AW'(ring_q);
            end
            S_OBS_EV2: begin
                run_waddr = AW'(ring_q);
                run_we    = (run_q != '0);
                run_wdata = run_q - CW'(1);
            end
            S_OBS_INC1: begin
                ring_we   = 1'b1;
                run_raddr = AW'(key_reg);
            end
            S_OBS_INC2: begin
                run_we    = 1'b1;
                run_waddr = AW'(key_reg);
                run_wdata = run_q + CW'(1);
            end
            S_SNAP_WR: begin
                ref_we    = 1'b1;
                ref_wdata = run_q;
            end
            default: begin
            end
        endcase
    end

    // Memories with registered reads.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= key_reg;
        end
        ring_q <= ring_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (run_we) begin
            run_mem[run_waddr] <= run_wdata;
        end
        run_q <= run_mem[run_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        ref_q <= ref_mem[idx_reg[AW-1:0]];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_start = (state_reg == S_MISSUE);
        mul_a     = mul_prod;
        mul_b     = '0;
        case (mstep_reg)
            MS_BEST_SQ: begin
                mul_a = MW'(best_reg);
                mul_b = BW'(best_reg);
            end
            MS_TIMES_N: begin
                mul_b = BW'(fill_reg);
            end
            MS_TIMES_K: begin
                mul_b = BW'(swks_pkg::CONF_SCALE);
            end
            MS_DEN_SQ: begin
                mul_a = MW'(den_reg);
                mul_b = BW'(den_reg);
            end
            MS_TIMES_C: begin
                mul_b = BW'(swks_pkg::two_c_sq(sig_cfg_reg));
            end
            default: begin
            end
        endcase
    end

    swks_mul #(
        .MW (MW),
        .BW (BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        rtot_next    = rtot_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        rc_next      = rc_reg;
        sc_next      = sc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        best_next    = best_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        mstep_next   = mstep_reg;
        lhs_next     = lhs_reg;
        chg_next     = chg_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                idx_next = idx_reg + DW'(1);
                if (32'(idx_reg) == DOMAIN_MAX - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    key_next  = in_key;
                    quo_next  = '0;
                    chg_next  = 1'b0;
                    err_next  = 1'b0;
                    idx_next  = '0;
                    rc_next   = '0;
                    sc_next   = '0;
                    best_next = '0;
                    den_next  = PW'(rtot_reg) * PW'(fill_reg);
                    case (swks_pkg::opcode_t'(in_op))
                        swks_pkg::OP_OBSERVE: begin
                            if (32'(in_key) >= 32'(eff_dom)) begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end else if (fill_reg >= eff_win) begin
                                state_next = S_OBS_EV1;
                            end else begin
                                state_next = S_OBS_INC1;
                            end
                        end
                        swks_pkg::OP_QUERY: begin
                            if (fill_reg == '0 || rtot_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_WALK_RD;
                            end
                        end
                        swks_pkg::OP_SNAPSHOT: begin
                            rtot_next  = fill_reg;
                            state_next = S_SNAP_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Eviction of the oldest key: read its count, then decrement it.
            S_OBS_EV1: begin
                state_next = S_OBS_EV2;
            end
            S_OBS_EV2: begin
                if (32'(head_reg) == WINDOW_MAX - 1) begin
                    head_next = '0;
                end else begin
                    head_next = head_reg + RW'(1);
                end
                fill_next  = fill_reg - CW'(1);
                state_next = S_OBS_INC1;
            end
            // Insertion of the new key into the ring and its histogram count.
            S_OBS_INC1: begin
                state_next = S_OBS_INC2;
            end
            S_OBS_INC2: begin
                fill_next  = fill_reg + CW'(1);
                state_next = S_DONE;
            end
            // Snapshot copy: read each histogram entry, then write it to the reference.
            S_SNAP_RD: begin
                state_next = S_SNAP_WR;
            end
            S_SNAP_WR: begin
                idx_next = idx_reg + DW'(1);
                if (32'(idx_reg) == DOMAIN_MAX - 1) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SNAP_RD;
                end
            end
            // Walk of the cumulative counts over the effective domain.
            S_WALK_RD: begin
                state_next = S_WALK_ACC;
            end
            S_WALK_ACC: begin
                rc_next    = rc_reg + ref_q;
                sc_next    = sc_reg + run_q;
                state_next = S_WALK_MUL;
            end
            S_WALK_MUL: begin
                x_next     = PW'(rc_reg) * PW'(fill_reg);
                y_next     = PW'(sc_reg) * PW'(rtot_reg);
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                best_next = best_upd;
                idx_next  = idx_reg + DW'(1);
                if (idx_reg + DW'(1) == eff_dom) begin
                    rem_next   = (PW + 1)'(best_upd);
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end else begin
                    state_next = S_WALK_RD;
                end
            end
            // Restoring division of best * 2^16 by the product of the totals.
            S_DIV: begin
                if (rem_sh >= (PW + 1)'(den_reg)) begin
                    rem_next = rem_sh - (PW + 1)'(den_reg);
                    quo_next = {quo_reg[swks_pkg::STAT_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[swks_pkg::STAT_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + swks_pkg::DCNT_W'(1);
                if (32'(dcnt_reg) == swks_pkg::KS_FRAC) begin
                    mstep_next = MS_BEST_SQ;
                    state_next = S_MISSUE;
                end
            end
            // Threshold products on the shared multiplier.
            S_MISSUE: begin
                state_next = S_MWAIT;
            end
            S_MWAIT: begin
                if (!mul_busy) begin
                    if (mstep_reg == MS_TIMES_K) begin
                        lhs_next = mul_prod;
                    end
                    if (mstep_reg == MS_TIMES_C) begin
                        chg_next   = (lhs_reg >= mul_prod);
                        state_next = S_DONE;
                    end else begin
                        mstep_next = mstep_reg + 3'd1;
                        state_next = S_MISSUE;
                    end
                end
            end
            // Result goes to the output register once it is free.
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {swks_pkg::FILL_W'(fill_reg), err_reg, chg_reg, quo_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dom_cfg_reg <= swks_pkg::DOMAIN_RESET;
            win_cfg_reg <= swks_pkg::WINDOW_RESET;
            sig_cfg_reg <= swks_pkg::SIG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                swks_pkg::REG_DOMAIN_SIZE: begin
                    dom_cfg_reg <= cfg_wdata[swks_pkg::DOM_CFG_W-1:0];
                end
                swks_pkg::REG_WINDOW_SIZE: begin
                    win_cfg_reg <= cfg_wdata[swks_pkg::WIN_CFG_W-1:0];
                end
                swks_pkg::REG_SIGNIFICANCE: begin
                    sig_cfg_reg <= cfg_wdata[swks_pkg::SIG_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            head_reg    <= '0;
            fill_reg    <= '0;
            rtot_reg    <= '0;
            idx_reg     <= '0;
            mstep_reg   <= MS_BEST_SQ;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            rtot_reg    <= rtot_next;
            idx_reg     <= idx_next;
            mstep_reg   <= mstep_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg    <= key_next;
        rc_reg     <= rc_next;
        sc_reg     <= sc_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        best_reg   <= best_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        lhs_reg    <= lhs_next;
        chg_reg    <= chg_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
